// File: rtl/core/rgb_fade_ramp_tint_assert.svh
// Assertion macros shared by the fade engine.
`ifndef RGB_FADE_RAMP_TINT_ASSERT_SVH
`define RGB_FADE_RAMP_TINT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFRT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/rfrt_pkg.sv
package rfrt_pkg;

   localparam int LEVEL_W = 9;
   localparam int STEPS_W = 10;
   localparam int BYTE_W  = 8;
   localparam int NUM_CH  = 3;
   localparam int DIV_ITER = LEVEL_W;
   localparam int CNT_W   = $clog2(DIV_ITER);

   localparam logic [LEVEL_W-1:0] NEUTRAL_LEVEL = 9'h100;
   localparam logic [LEVEL_W-1:0] ADDITIVE_FROM = 9'h101;

   localparam logic KIND_SET  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [NUM_CH-1:0][LEVEL_W-1:0] rgb_type;

   typedef struct packed {
      logic start;
      logic shift;
   } lane_ctl_type;

   typedef struct packed {
      logic              visible;
      logic              subtractive;
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } tint_type;

endpackage

// File: rtl/core/rfrt_lane.sv
module rfrt_lane (
   input  logic                          clock,
   input  rfrt_pkg::lane_ctl_type        ctl,
   input  logic [rfrt_pkg::LEVEL_W-1:0]  level,
   input  logic [rfrt_pkg::LEVEL_W-1:0]  goal,
   input  logic [rfrt_pkg::STEPS_W-1:0]  steps,
   output logic [rfrt_pkg::LEVEL_W-1:0]  next_level
);
   import rfrt_pkg::*;

   logic [LEVEL_W-1:0] dvd_ff, quo_ff;
   logic [STEPS_W-1:0] rem_ff;
   logic               neg_ff;

   logic [LEVEL_W:0]   diff;
   logic [LEVEL_W:0]   diff_abs;
   logic [STEPS_W:0]   trial;
   logic [STEPS_W:0]   reduced;
   logic               fits;

   // The difference is taken apart into sign and magnitude, and the
   // magnitude is divided one quotient bit per cycle, most significant first.
   assign diff     = {1'b0, goal} - {1'b0, level};
   assign diff_abs = diff[LEVEL_W] ? (~diff + 1'b1) : diff;
   assign trial    = {rem_ff, dvd_ff[LEVEL_W-1]};
   assign fits     = trial >= {1'b0, steps};
   assign reduced  = trial - {1'b0, steps};

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         dvd_ff <= diff_abs[LEVEL_W-1:0];
         rem_ff <= '0;
         quo_ff <= '0;
         neg_ff <= diff[LEVEL_W];
      end else if (ctl.shift) begin
         dvd_ff <= {dvd_ff[LEVEL_W-2:0], 1'b0};
         rem_ff <= fits ? reduced[STEPS_W-1:0] : trial[STEPS_W-1:0];
         quo_ff <= {quo_ff[LEVEL_W-2:0], fits};
      end
   end

   assign next_level = neg_ff ? (level - quo_ff) : (level + quo_ff);

endmodule

// File: rtl/core/rfrt_tint.sv
module rfrt_tint (
   input  rfrt_pkg::rgb_type  levels,
   output rfrt_pkg::tint_type tint
);
   import rfrt_pkg::*;

   logic [NUM_CH-1:0][BYTE_W-1:0] add_bytes;
   logic [NUM_CH-1:0][BYTE_W-1:0] sub_bytes;
   logic                          neutral;
   logic                          additive;

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         add_bytes[i] = BYTE_W'(levels[i] - 1'b1);
         sub_bytes[i] = (levels[i] == NEUTRAL_LEVEL) ? '0 : ~levels[i][BYTE_W-1:0];
      end
   end

   assign neutral  = (levels[0] == NEUTRAL_LEVEL) && (levels[1] == NEUTRAL_LEVEL) &&
                     (levels[2] == NEUTRAL_LEVEL);
   assign additive = levels[0] >= ADDITIVE_FROM;

   always_comb begin
      tint = '0;
      if (!neutral) begin
         tint.visible     = 1'b1;
         tint.subtractive = !additive;
         tint.red         = additive ? add_bytes[0] : sub_bytes[0];
         tint.green       = additive ? add_bytes[1] : sub_bytes[1];
         tint.blue        = additive ? add_bytes[2] : sub_bytes[2];
      end
   end

endmodule

// File: rtl/core/rgb_fade_ramp_tint.sv
// Channel   Direction  Handshake            Contents
// req       in         tvalid/tready        tuser kind, tdata target levels and steps
// rsp       out        tvalid/tready        tuser visible/subtractive, tdata tint bytes
//
// A set-target request gives no response.
// A tick with steps remaining starts the bit-serial dividers (one per channel,
// running side by side) when it is taken, shifts them in ST_DIV, then finishes in ST_FIN.
// A tick with no steps left snaps to the goal and goes straight to the finishing state.
// The finishing cycle waits while an earlier response is still held.
// Reset is synchronous and clears the levels, goals and step count to zero.
module rgb_fade_ramp_tint (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // kind
   input  logic [39:0] req_tdata,   // target_red, target_green, target_blue, ramp_steps
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // visible, subtractive
   output logic [23:0] rsp_tdata    // tint_red, tint_green, tint_blue
);
   import rfrt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_ITER - 1);

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               snap_ff, snap_in;
   rgb_type            level_ff, level_in;
   rgb_type            goal_ff, goal_in;
   logic [STEPS_W-1:0] steps_ff, steps_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tint_type           rsp_ff, rsp_in;

   lane_ctl_type       lane_ctl;
   rgb_type            lane_level;
   rgb_type            new_level;
   tint_type           tint;
   logic               req_acc;
   logic               rsp_free;

   assign req_tready = state_ff == ST_IDLE;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign lane_ctl.start = req_acc && (req_tuser == KIND_TICK) && (steps_ff != '0);
   assign lane_ctl.shift = state_ff == ST_DIV;

   for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
      rfrt_lane u_lane (
         .clock      (clock),
         .ctl        (lane_ctl),
         .level      (level_ff[g]),
         .goal       (goal_ff[g]),
         .steps      (steps_ff),
         .next_level (lane_level[g])
      );
   end

   assign new_level = snap_ff ? goal_ff : lane_level;

   rfrt_tint u_tint (
      .levels (new_level),
      .tint   (tint)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      snap_in      = snap_ff;
      level_in     = level_ff;
      goal_in      = goal_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == KIND_SET) begin
                  goal_in[0] = req_tdata[8:0];
                  goal_in[1] = req_tdata[17:9];
                  goal_in[2] = req_tdata[26:18];
                  steps_in   = req_tdata[36:27];
               end else begin
                  cnt_in   = '0;
                  snap_in  = steps_ff == '0;
                  state_in = (steps_ff == '0) ? ST_FIN : ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               level_in     = new_level;
               steps_in     = snap_ff ? steps_ff : steps_ff - 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = tint;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         snap_ff      <= 1'b0;
         level_ff     <= '0;
         goal_ff      <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         snap_ff      <= snap_in;
         level_ff     <= level_in;
         goal_ff      <= goal_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ff.subtractive, rsp_ff.visible};
   assign rsp_tdata  = {rsp_ff.blue, rsp_ff.green, rsp_ff.red};

`include "rgb_fade_ramp_tint_assert.svh"

   `RFRT_ASSERT_SAME(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FIN, "response raised outside the finishing cycle")
   `RFRT_ASSERT_NEXT(a_set_silent, clock, reset, req_acc && (req_tuser == KIND_SET) && !rsp_valid_ff, !rsp_valid_ff, "set-target request produced a response")
   `RFRT_ASSERT_NEXT(a_div_length, clock, reset, (state_ff == ST_DIV) && (cnt_ff == CNT_LAST), state_ff == ST_FIN, "divider did not finish after its last bit")

endmodule
